FILE: sv/pad_pkg.sv
// Package for the PWM audio duty FIFO: sizes, duty constants, command and
// configuration register codes. No dependencies.
package pad_pkg;

  localparam int unsigned FifoPairs = 256;
  localparam int unsigned FifoAw    = $clog2(FifoPairs);

  localparam int unsigned SampleW = 16;
  localparam int unsigned VolW    = 17;
  localparam int unsigned DecimW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [VolW-1:0]    VolFull  = 17'd65536;
  localparam logic [SampleW-1:0] SignFlip = 16'h8000;
  localparam logic [SampleW-1:0] DutyHalf = 16'h8000;
  localparam logic [SampleW-1:0] DutyMax  = 16'hffff;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSample16  = 2'd0,
    CfgDecim     = 2'd1,
    CfgVolLeft   = 2'd2,
    CfgVolRight  = 2'd3
  } cfg_idx_e;

endpackage

FILE: sv/pad_duty.sv
// One channel of the duty datapath: volume multiply and offset, a register,
// then an exact divide by 65535 with saturation. Depends on pad_pkg.
module pad_duty (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          is_16bit_i,
  input  logic [pad_pkg::SampleW-1:0]   raw_i,
  input  logic [pad_pkg::VolW-1:0]      vol_i,
  output logic [pad_pkg::SampleW-1:0]   duty_o
);

  logic [pad_pkg::VolW-1:0]    vol_c;
  logic [pad_pkg::SampleW-1:0] u;
  logic [pad_pkg::VolW-1:0]    k;
  logic [32:0]                 off_full;
  logic [32:0]                 prod;
  logic [32:0]                 x_d;
  logic [32:0]                 x_q;
  logic [16:0]                 a;
  logic [17:0]                 s;
  logic [17:0]                 q;
  logic [1:0]                  c;

  // An 8-bit sample times 257 is the byte repeated, which turns the divide
  // by 255 into the same divide by 65535 that 16-bit samples use.
  assign vol_c = (vol_i > pad_pkg::VolFull) ? pad_pkg::VolFull : vol_i;
  assign u     = is_16bit_i ? (raw_i ^ pad_pkg::SignFlip) : {raw_i[7:0], raw_i[7:0]};
  assign k     = 17'(pad_pkg::VolFull + 17'd1 - vol_c);
  assign off_full = {k, 16'b0} - {16'b0, k};
  assign prod  = 33'(u) * 33'(vol_c);
  assign x_d   = prod + {1'b0, off_full[32:1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
    end
  end

  assign a = x_q[32:16];
  assign s = {1'b0, a} + {2'b0, x_q[15:0]};

  always_comb begin
    if (s >= 18'd131070) begin
      c = 2'd2;
    end else if (s >= 18'd65535) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
  end

  assign q      = {1'b0, a} + {16'b0, c};
  assign duty_o = (q > {2'b0, pad_pkg::DutyMax}) ? pad_pkg::DutyMax : q[15:0];

endmodule

FILE: sv/pwm_audio_duty_fifo.sv
// Top level of the PWM audio duty FIFO: decimation, duty computation, the duty
// ring memory and the tick playout. Depends on pad_pkg and pad_duty.

// A new word is accepted in every cycle unless in_stall_o holds it, samples and
// ticks alike, and each word gives exactly one result: it passes the input
// register, a stage that finishes the duty divide and writes or reads the
// 256-entry duty memory, and the output register.
// The FIFO keeps one entry free, so it holds 255 stereo pairs; a sample pair
// that meets a full FIFO returns accepted at zero and must be sent again.
// The memory needs no clearing after reset.
module pwm_audio_duty_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pad_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pad_pkg::VolW-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [pad_pkg::SampleW-1:0]       left_sample_i,
  input  logic [pad_pkg::SampleW-1:0]       right_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              accepted_o,
  output logic                              duty_update_o,
  output logic [pad_pkg::SampleW-1:0]       duty_left_o,
  output logic [pad_pkg::SampleW-1:0]       duty_right_o,
  output logic                              is_playing_o
);

  typedef struct packed {
    logic                       accepted;
    logic                       wr;
    logic                       rd;
    logic                       half;
    logic                       playing;
    logic [pad_pkg::FifoAw-1:0] addr;
  } mid_ctl_t;

  typedef struct packed {
    logic accepted;
    logic update;
    logic from_mem;
    logic playing;
  } out_ctl_t;

  logic                          sample_is_16bit_q;
  logic [pad_pkg::DecimW-1:0]    decimation_factor_q;
  logic [pad_pkg::VolW-1:0]      volume_left_q;
  logic [pad_pkg::VolW-1:0]      volume_right_q;

  logic [pad_pkg::FifoAw-1:0]    wp_q, wp_d;
  logic [pad_pkg::FifoAw-1:0]    rp_q, rp_d;
  logic [pad_pkg::DecimW-1:0]    skip_q, skip_d;
  logic                          playing_q, playing_d;

  logic                          s1_valid_q;
  logic                          s1_cmd_q;
  logic [pad_pkg::SampleW-1:0]   s1_left_q;
  logic [pad_pkg::SampleW-1:0]   s1_right_q;
  logic                          s2_valid_q;
  mid_ctl_t                      s2_ctl_q, s2_ctl_d;
  logic                          s3_valid_q;
  out_ctl_t                      s3_ctl_q;
  logic [31:0]                   rdata_q;

  logic [31:0]                   mem [pad_pkg::FifoPairs];

  logic                          s1_free, s2_free, s3_free, s1_adv, s2_adv, in_acc;
  logic [pad_pkg::DecimW-1:0]    factor_m1;
  logic [pad_pkg::FifoAw-1:0]    wp_next;
  logic [pad_pkg::SampleW-1:0]   duty_left, duty_right;

  assign s3_free    = !s3_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && s3_free;
  assign s2_free    = !s2_valid_q || s3_free;
  assign s1_adv     = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= cmd_i;
      s1_left_q  <= left_sample_i;
      s1_right_q <= right_sample_i;
    end
  end

  assign factor_m1 = (decimation_factor_q == '0) ? '0 : decimation_factor_q - 3'd1;
  assign wp_next   = wp_q + 1'b1;

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    skip_d    = skip_q;
    playing_d = playing_q;
    s2_ctl_d  = '0;
    if (s1_cmd_q == pad_pkg::CmdSample) begin
      if (skip_q < factor_m1) begin
        skip_d            = skip_q + 3'd1;
        s2_ctl_d.accepted = 1'b1;
      end else if (wp_next != rp_q) begin
        s2_ctl_d.wr       = 1'b1;
        s2_ctl_d.addr     = wp_q;
        s2_ctl_d.accepted = 1'b1;
        wp_d              = wp_next;
        skip_d            = '0;
      end
    end else begin
      if (rp_q != wp_q) begin
        s2_ctl_d.rd   = 1'b1;
        s2_ctl_d.addr = rp_q;
        rp_d          = rp_q + 1'b1;
        playing_d     = 1'b1;
      end else if (playing_q) begin
        s2_ctl_d.half = 1'b1;
        playing_d     = 1'b0;
      end
    end
    s2_ctl_d.playing = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_is_16bit_q   <= 1'b1;
      decimation_factor_q <= 3'd5;
      volume_left_q       <= pad_pkg::VolFull;
      volume_right_q      <= pad_pkg::VolFull;
      wp_q                <= '0;
      rp_q                <= '0;
      skip_q              <= '0;
      playing_q           <= 1'b0;
      s1_valid_q          <= 1'b0;
      s2_valid_q          <= 1'b0;
      s2_ctl_q            <= '0;
      s3_valid_q          <= 1'b0;
      s3_ctl_q            <= '0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s1_adv) begin
        wp_q      <= wp_d;
        rp_q      <= rp_d;
        skip_q    <= skip_d;
        playing_q <= playing_d;
        s2_ctl_q  <= s2_ctl_d;
      end
      if (s2_adv) begin
        s3_ctl_q.accepted <= s2_ctl_q.accepted;
        s3_ctl_q.update   <= s2_ctl_q.rd || s2_ctl_q.half;
        s3_ctl_q.from_mem <= s2_ctl_q.rd;
        s3_ctl_q.playing  <= s2_ctl_q.playing;
      end
      if (cfg_we_i) begin
        case (pad_pkg::cfg_idx_e'(cfg_index_i))
          pad_pkg::CfgSample16: begin
            sample_is_16bit_q <= cfg_wdata_i[0];
            skip_q            <= '0;
          end
          pad_pkg::CfgDecim: begin
            decimation_factor_q <= cfg_wdata_i[pad_pkg::DecimW-1:0];
            skip_q              <= '0;
          end
          pad_pkg::CfgVolLeft: begin
            volume_left_q <= cfg_wdata_i;
            skip_q        <= '0;
          end
          pad_pkg::CfgVolRight: begin
            volume_right_q <= cfg_wdata_i;
            skip_q         <= '0;
          end
          default: begin
            skip_q <= skip_q;
          end
        endcase
      end
    end
  end

  pad_duty u_duty_left (
    .clk_i      (clk_i),
    .en_i       (s1_adv),
    .is_16bit_i (sample_is_16bit_q),
    .raw_i      (s1_left_q),
    .vol_i      (volume_left_q),
    .duty_o     (duty_left)
  );

  pad_duty u_duty_right (
    .clk_i      (clk_i),
    .en_i       (s1_adv),
    .is_16bit_i (sample_is_16bit_q),
    .raw_i      (s1_right_q),
    .vol_i      (volume_right_q),
    .duty_o     (duty_right)
  );

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_ctl_q.wr) begin
      mem[s2_ctl_q.addr] <= {duty_left, duty_right};
    end
    if (s2_adv && s2_ctl_q.rd) begin
      rdata_q <= mem[s2_ctl_q.addr];
    end
  end

  assign out_valid_o   = s3_valid_q;
  assign accepted_o    = s3_ctl_q.accepted;
  assign duty_update_o = s3_ctl_q.update;
  assign is_playing_o  = s3_ctl_q.playing;
  assign duty_left_o   = !s3_ctl_q.update ? '0 :
                         (s3_ctl_q.from_mem ? rdata_q[31:16] : pad_pkg::DutyHalf);
  assign duty_right_o  = !s3_ctl_q.update ? '0 :
                         (s3_ctl_q.from_mem ? rdata_q[15:0] : pad_pkg::DutyHalf);

  a_acc_xor_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && duty_update_o))
    else $error("A result reports both a taken sample pair and a duty update.");

  a_zero_without_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !duty_update_o) |-> (duty_left_o == '0 && duty_right_o == '0))
    else $error("Duties are nonzero on a result without a duty update.");

  a_play_stops_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(playing_q) |-> $past(s1_adv && s1_cmd_q == pad_pkg::CmdTick && rp_q == wp_q))
    else $error("Playback stopped without a tick on an empty FIFO.");

endmodule

FILE: sim/pwm_audio_duty_fifo_tb.sv
// Testbench for pwm_audio_duty_fifo: it checks decimation, duty scaling, the ring FIFO and
// tick playout against its own duty model, under random idling and output back-pressure.
// Depends on pad_pkg and the pwm_audio_duty_fifo RTL.
module pwm_audio_duty_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        accepted;
    logic                        update;
    logic [pad_pkg::SampleW-1:0] duty_left;
    logic [pad_pkg::SampleW-1:0] duty_right;
    logic                        playing;
  } duty_word_t;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned TailCycles    = 10;
  localparam int unsigned MaxPrinted    = 20;
  localparam int unsigned PhaseWords    = 35;
  localparam longint unsigned Norm8     = 255;
  localparam longint unsigned Norm16    = 65535;
  localparam int IdleSend  [4] = '{0, 47, 0, 25};
  localparam int IdleStall [4] = '{0, 0, 47, 25};
  localparam int DecimPick [8] = '{1, 0, 7, 6, 2, 3, 4, 5};

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [pad_pkg::CfgIdxW-1:0] cfg_index_i    = '0;
  logic [pad_pkg::VolW-1:0]    cfg_wdata_i    = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic                        cmd_i          = pad_pkg::CmdSample;
  logic [pad_pkg::SampleW-1:0] left_sample_i  = '0;
  logic [pad_pkg::SampleW-1:0] right_sample_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic                        accepted_o;
  logic                        duty_update_o;
  logic [pad_pkg::SampleW-1:0] duty_left_o;
  logic [pad_pkg::SampleW-1:0] duty_right_o;
  logic                        is_playing_o;

  logic               hold_stall     = 1'b0;
  int                 stall_pct      = 0;
  int                 send_idle_pct  = 0;
  int                 mismatches     = 0;
  int                 idle_cycles    = 0;

  logic [2*pad_pkg::SampleW-1:0] duty_ring [pad_pkg::FifoPairs];
  logic [pad_pkg::FifoAw-1:0]    ring_wr       = '0;
  logic [pad_pkg::FifoAw-1:0]    ring_rd       = '0;
  logic [2:0]                    skip_cnt      = '0;
  logic                          playing       = 1'b0;
  logic                          cfg_16bit     = 1'b1;
  logic [pad_pkg::DecimW-1:0]    cfg_decim     = 3'd5;
  logic [pad_pkg::VolW-1:0]      cfg_vol_left  = pad_pkg::VolFull;
  logic [pad_pkg::VolW-1:0]      cfg_vol_right = pad_pkg::VolFull;
  duty_word_t                    pending_duties [$];

  pwm_audio_duty_fifo i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .duty_update_o  (duty_update_o),
    .duty_left_o    (duty_left_o),
    .duty_right_o   (duty_right_o),
    .is_playing_o   (is_playing_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= hold_stall || ($urandom_range(99) < stall_pct);
  end

  function automatic logic [pad_pkg::SampleW-1:0] scale_duty(
      logic [pad_pkg::SampleW-1:0] raw, logic [pad_pkg::VolW-1:0] vol);
    longint unsigned u, m, v, q;
    v = (vol > pad_pkg::VolFull) ? pad_pkg::VolFull : vol;
    if (cfg_16bit) begin
      u = raw ^ pad_pkg::SignFlip;
      m = Norm16;
    end else begin
      u = raw[7:0];
      m = Norm8;
    end
    q = (2 * u * v + m * (pad_pkg::VolFull - v) + m) / (2 * m);
    return (q > pad_pkg::DutyMax) ? pad_pkg::DutyMax : q[pad_pkg::SampleW-1:0];
  endfunction

  function automatic void predict_duty_word(logic cmd, logic [pad_pkg::SampleW-1:0] l,
                                            logic [pad_pkg::SampleW-1:0] r);
    duty_word_t                 w;
    logic [2:0]                 factor;
    logic [pad_pkg::FifoAw-1:0] nxt;
    w = '0;
    if (cmd == pad_pkg::CmdSample) begin
      factor = (cfg_decim == 3'd0) ? 3'd1 : cfg_decim;
      if (skip_cnt < factor - 3'd1) begin
        skip_cnt = skip_cnt + 3'd1;
        w.accepted = 1'b1;
      end else begin
        nxt = ring_wr + 1'b1;
        if (nxt != ring_rd) begin
          duty_ring[ring_wr] = {scale_duty(l, cfg_vol_left), scale_duty(r, cfg_vol_right)};
          ring_wr = nxt;
          skip_cnt = '0;
          w.accepted = 1'b1;
        end
      end
    end else if (ring_rd != ring_wr) begin
      {w.duty_left, w.duty_right} = duty_ring[ring_rd];
      w.update = 1'b1;
      ring_rd = ring_rd + 1'b1;
      playing = 1'b1;
    end else if (playing) begin
      w.duty_left = pad_pkg::DutyHalf;
      w.duty_right = pad_pkg::DutyHalf;
      w.update = 1'b1;
      playing = 1'b0;
    end
    w.playing = playing;
    pending_duties.push_back(w);
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MaxPrinted) $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic check_duty_word();
    duty_word_t want;
    if (pending_duties.size() == 0) begin
      report_mismatch("result word with no expectation waiting");
      return;
    end
    want = pending_duties.pop_front();
    if (accepted_o !== want.accepted)
      report_mismatch($sformatf("accepted got %0d expected %0d", accepted_o, want.accepted));
    if (duty_update_o !== want.update)
      report_mismatch($sformatf("duty_update got %0d expected %0d", duty_update_o,
                                want.update));
    if (duty_left_o !== want.duty_left)
      report_mismatch($sformatf("duty_left got %h expected %h", duty_left_o, want.duty_left));
    if (duty_right_o !== want.duty_right)
      report_mismatch($sformatf("duty_right got %h expected %h", duty_right_o,
                                want.duty_right));
    if (is_playing_o !== want.playing)
      report_mismatch($sformatf("is_playing got %0d expected %0d", is_playing_o,
                                want.playing));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_duty_word(cmd_i, left_sample_i, right_sample_i);
      if (out_valid_o && !out_stall_i) check_duty_word();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i)) begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("** pwm_audio_duty_fifo: FAILED **");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic send_word(logic cmd, logic [pad_pkg::SampleW-1:0] l,
                           logic [pad_pkg::SampleW-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    left_sample_i  <= l;
    right_sample_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_word(int tick_pct);
    send_word(($urandom_range(99) < tick_pct) ? pad_pkg::CmdTick : pad_pkg::CmdSample,
              pad_pkg::SampleW'($urandom), pad_pkg::SampleW'($urandom));
  endtask

  task automatic release_input();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(pad_pkg::cfg_idx_e idx, logic [pad_pkg::VolW-1:0] data);
    release_input();
    while (pending_duties.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pad_pkg::CfgSample16: cfg_16bit = data[0];
      pad_pkg::CfgDecim:    cfg_decim = data[pad_pkg::DecimW-1:0];
      pad_pkg::CfgVolLeft:  cfg_vol_left = data;
      pad_pkg::CfgVolRight: cfg_vol_right = data;
      default:              ;
    endcase
    skip_cnt = '0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_word(pad_pkg::CmdTick, '0, '0);
    write_reg(pad_pkg::CfgDecim, 17'd1);
    send_word(pad_pkg::CmdSample, 16'h7fff, 16'h8000);
    send_word(pad_pkg::CmdSample, 16'h8000, 16'h7fff);
    send_word(pad_pkg::CmdSample, 16'h0000, 16'hffff);
    send_word(pad_pkg::CmdSample, 16'h1234, 16'hedcb);
    write_reg(pad_pkg::CfgVolLeft, 17'd0);
    write_reg(pad_pkg::CfgVolRight, 17'h1ffff);
    send_word(pad_pkg::CmdSample, 16'h7fff, 16'h7fff);
    write_reg(pad_pkg::CfgSample16, 17'd0);
    send_word(pad_pkg::CmdSample, 16'h00ff, 16'hff00);
    send_word(pad_pkg::CmdSample, 16'h0080, 16'h0001);
    repeat (9) send_word(pad_pkg::CmdTick, pad_pkg::SampleW'($urandom),
                         pad_pkg::SampleW'($urandom));
  endtask

  task automatic test_random_mix();
    logic [pad_pkg::VolW-1:0] vol_pick [4];
    for (int p = 0; p < 8; p++) begin
      vol_pick = '{17'd0, pad_pkg::VolFull, 17'h1ffff,
                   pad_pkg::VolW'($urandom_range(65536))};
      set_idling(IdleSend[p % 4], IdleStall[p % 4]);
      write_reg(pad_pkg::CfgSample16, pad_pkg::VolW'(p[0]));
      write_reg(pad_pkg::CfgDecim, pad_pkg::VolW'(DecimPick[p]));
      write_reg(pad_pkg::CfgVolLeft, vol_pick[p % 4]);
      write_reg(pad_pkg::CfgVolRight, vol_pick[3 - p % 4]);
      repeat (PhaseWords) send_random_word(p[1] ? 55 : 20);
    end
  endtask

  task automatic test_fifo_full();
    set_idling(25, 25);
    write_reg(pad_pkg::CfgDecim, 17'd1);
    repeat (pad_pkg::FifoPairs + 4) send_random_word(0);
    write_reg(pad_pkg::CfgDecim, 17'd3);
    repeat (6) send_random_word(0);
    repeat (2) send_random_word(100);
    repeat (3) send_random_word(0);
    repeat (pad_pkg::FifoPairs + 2) send_random_word(100);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    write_reg(pad_pkg::CfgDecim, 17'd1);
    fork
      begin
        hold_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_stall <= 1'b0;
      end
    join_none
    repeat (40) send_random_word(40);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix();
    test_fifo_full();
    test_backpressure();
    release_input();
    while (pending_duties.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** pwm_audio_duty_fifo: PASSED **");
    end else begin
      $display("** pwm_audio_duty_fifo: FAILED **");
    end
    $finish;
  end

endmodule
